FILE: rtl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and encoding functions for the UTF-16 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_t;

  localparam int CP_W        = 21;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [5:0]      HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0]      LOW_SURR_TAG  = 6'b110111;
  localparam logic [CP_W-1:0] PAIR_BASE     = 21'h010000;

  // At most one job per accepted unit: an optional flushed surrogate, then an
  // optional main code point.
  typedef struct packed {
    logic            flush;
    logic [9:0]      flush_bits;
    logic            main_valid;
    logic [CP_W-1:0] cp;
    logic            last;
  } job_t;

  function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
    logic [2:0] len;
    if (cp < 21'h000080) begin
      len = 3'd1;
    end else if (cp < 21'h000800) begin
      len = 3'd2;
    end else if (cp < 21'h010000) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                           input logic [2:0] len,
                                           input logic [1:0] idx);
    logic [1:0] rem;
    logic [7:0] b;
    rem = 2'(len - 3'd1 - {1'b0, idx});
    if (len == 3'd1) begin
      b = cp[7:0];
    end else if (idx == 2'd0) begin
      unique case (len)
        3'd2:    b = {3'b110, cp[10:6]};
        3'd3:    b = {4'b1110, cp[15:12]};
        default: b = {5'b11110, cp[20:18]};
      endcase
    end else begin
      unique case (rem)
        2'd0:    b = {2'b10, cp[5:0]};
        2'd1:    b = {2'b10, cp[11:6]};
        default: b = {2'b10, cp[17:12]};
      endcase
    end
    return b;
  endfunction

endpackage

FILE: rtl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, tracks a held high surrogate and builds at most one job
// per unit for the byte serializer.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  u16u8_pkg::in_t    in_data,
  input  logic              q_full,
  output logic              push,
  output u16u8_pkg::job_t   push_data
);
  import u16u8_pkg::*;

  logic       held_valid;
  logic [9:0] held_bits;
  logic       is_high;
  logic       is_low;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_high  = in_data.code_unit[15:10] == HIGH_SURR_TAG;
  assign is_low   = in_data.code_unit[15:10] == LOW_SURR_TAG;

  always_comb begin
    push_data.flush      = held_valid && !is_low;
    push_data.flush_bits = held_bits;
    push_data.main_valid = !(is_high && !in_data.end_of_string);
    if (held_valid && is_low) begin
      push_data.cp = PAIR_BASE + {1'b0, held_bits, in_data.code_unit[9:0]};
    end else begin
      push_data.cp = {5'b0, in_data.code_unit};
    end
    push_data.last = in_data.end_of_string;
  end

  assign push = accept && (push_data.flush || push_data.main_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= is_high && !in_data.end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_bits <= in_data.code_unit[9:0];
    end
  end

endmodule

FILE: rtl/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// Short job queue that decouples the classifier from the byte serializer.
// ----------------------------------------------------------------------------
module u16u8_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u16u8_pkg::job_t push_data,
  output logic            full,
  output logic            head_valid,
  output u16u8_pkg::job_t head_data,
  input  logic            pop
);
  import u16u8_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_data  = entries[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Takes jobs from the queue and emits their UTF-8 bytes one per cycle, while
// the receiver keeps up, through an output register.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  u16u8_pkg::job_t head_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output u16u8_pkg::out_t out_data
);
  import u16u8_pkg::*;

  job_t            job;
  logic            active;
  logic            in_flush;
  logic [1:0]      idx;
  logic [CP_W-1:0] cur_cp;
  logic [2:0]      cur_len;
  logic            seg_end;
  logic            job_end;
  logic            load;

  always_comb begin
    if (in_flush) begin
      cur_cp  = {5'b0, HIGH_SURR_TAG, job.flush_bits};
      cur_len = 3'd3;
    end else begin
      cur_cp  = job.cp;
      cur_len = utf8_len(job.cp);
    end
  end

  assign seg_end = idx == 2'(cur_len - 3'd1);
  assign job_end = seg_end && (!in_flush || !job.main_valid);
  assign load    = active && (!out_valid || out_ready);
  assign pop     = head_valid && (!active || (load && job_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      in_flush  <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active   <= 1'b1;
        in_flush <= head_data.flush;
        idx      <= '0;
      end else if (load) begin
        if (job_end) begin
          active <= 1'b0;
        end else if (seg_end) begin
          in_flush <= 1'b0;
          idx      <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head_data;
    end
    if (load) begin
      out_data.out_byte  <= utf8_byte(cur_cp, cur_len, idx);
      out_data.last_byte <= job_end && job.last;
    end
  end

endmodule

FILE: rtl/utf16_to_utf8_transcoder_unit.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_unit
// UTF-16 code units in, UTF-8 bytes out, with WTF-8 handling of unpaired
// surrogates.
// ----------------------------------------------------------------------------
// The input channel takes one code unit per transfer with an end-of-string
// flag. The output channel gives one UTF-8 byte per transfer; last_byte marks
// the final byte of a string. Both channels use valid/ready handshakes.
// A high surrogate that does not end the string is held and produces no byte
// until the next unit arrives. A unit then yields zero to six bytes.
// The first byte of a unit passes through the job queue, the job register and
// the output register before it appears on the output. The serializer emits
// one byte per cycle while the receiver keeps up. A unit has one byte for ASCII,
// three for most other BMP text, four per surrogate pair. A two-entry job
// queue lets units keep arriving while earlier bytes drain; in_ready drops
// only when it is full. When the receiver stalls, the output byte holds and
// the queue fills, then the input stalls. Reset clears the held surrogate,
// the queue and the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  u16u8_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output u16u8_pkg::out_t out_data
);
  import u16u8_pkg::*;

  logic q_full;
  logic push;
  job_t push_data;
  logic head_valid;
  job_t head_data;
  logic pop;

  u16u8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  u16u8_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

FILE: rtl/u16u8_checker.sv
// ----------------------------------------------------------------------------
// u16u8_checker
// Port-level assertions for the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
module u16u8_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input u16u8_pkg::out_t out_data
);
  import u16u8_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled output byte changed before its transfer.");

  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("Output valid right after reset.");

  a_last_not_lead: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last_byte |-> out_data.out_byte[7:6] != 2'b11)
    else $error("String ends on a lead byte.");

  a_legal_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.out_byte != 8'hC0 && out_data.out_byte != 8'hC1 &&
                  out_data.out_byte[7:3] != 5'b11111)
    else $error("Output byte is never legal in UTF-8.");

endmodule

bind utf16_to_utf8_transcoder_unit u16u8_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: bench/utf16_to_utf8_transcoder_unit_tb.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_unit_tb
// Self-checking bench for the UTF-16 to UTF-8 transcoder unit.
// ----------------------------------------------------------------------------
// Every accepted code unit goes to a scoreboard. The scoreboard tracks the held
// high surrogate on its own and queues the UTF-8 bytes that the unit should
// produce. Each byte the block delivers is checked against that queue. A short
// directed sequence covers the encoding boundaries and the surrogate cases.
// Random strings follow, weighted toward well-formed surrogate pairs. The
// sender works in bursts with gaps, and the receiver cycles through several
// stall patterns.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_unit_tb;
  import u16u8_pkg::*;

  localparam int RANDOM_UNITS = 250;
  localparam int IDLE_LIMIT   = 2000;

  class utf8_scoreboard;
    out_t       expected_bytes[$];
    bit         held_valid;
    bit [9:0]   held_bits;
    int         errors;
    int         units_seen;
    int         bytes_checked;
    int         pairs_seen;
    int         flushes_seen;

    function void push_byte(bit [7:0] value);
      out_t b;
      b.out_byte  = value;
      b.last_byte = 1'b0;
      expected_bytes.push_back(b);
    endfunction

    function void push_point(bit [20:0] cp);
      if (cp < 21'h80) begin
        push_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
        push_byte(8'hC0 | 8'(cp >> 6));
        push_byte(8'h80 | 8'(cp & 21'h3F));
      end else if (cp < 21'h10000) begin
        push_byte(8'hE0 | 8'(cp >> 12));
        push_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
        push_byte(8'h80 | 8'(cp & 21'h3F));
      end else begin
        push_byte(8'hF0 | 8'(cp >> 18));
        push_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
        push_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
        push_byte(8'h80 | 8'(cp & 21'h3F));
      end
    endfunction

    function void mark_last(bit eos);
      out_t b;
      if (eos) begin
        b = expected_bytes.pop_back();
        b.last_byte = 1'b1;
        expected_bytes.push_back(b);
      end
    endfunction

    function void note_unit(in_t u);
      bit is_high;
      bit is_low;
      is_high = u.code_unit >= 16'hD800 && u.code_unit <= 16'hDBFF;
      is_low  = u.code_unit >= 16'hDC00 && u.code_unit <= 16'hDFFF;
      units_seen++;
      if (held_valid) begin
        held_valid = 1'b0;
        if (is_low) begin
          push_point(21'h10000 + {1'b0, held_bits, u.code_unit[9:0]});
          mark_last(u.end_of_string);
          pairs_seen++;
          held_bits = '0;
          return;
        end
        push_point(21'hD800 + 21'(held_bits));
        flushes_seen++;
        held_bits = '0;
      end
      if (is_high && !u.end_of_string) begin
        held_valid = 1'b1;
        held_bits  = u.code_unit[9:0];
        return;
      end
      push_point({5'b0, u.code_unit});
      mark_last(u.end_of_string);
    endfunction

    function void check_byte(out_t got);
      out_t want;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte, expected none, actual byte %02h last %0b",
                 $time, got.out_byte, got.last_byte);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                 $time, want.out_byte, got.out_byte);
      end
      if (got.last_byte !== want.last_byte) begin
        errors++;
        $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                 $time, want.last_byte, got.last_byte);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  utf8_scoreboard sb;
  int units_sent;
  int burst_left;
  int rx_cycle;
  int stall_left;
  int idle_cycles;

  utf16_to_utf8_transcoder_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_unit(in_data);
      end
      if (out_valid && out_ready) begin
        sb.check_byte(out_data);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    rx_cycle++;
    case ((rx_cycle / 128) % 3)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_left = $urandom_range(5, 20);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  task automatic send_unit(input logic [15:0] cu, input logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{code_unit: cu, end_of_string: eos};
    do @(posedge clk); while (!in_ready);
    units_sent++;
  endtask

  task automatic send_random_unit();
    int pick;
    logic eos;
    pick = $urandom_range(0, 99);
    eos  = ($urandom_range(0, 7) == 0);
    if (pick < 30) begin
      send_unit(16'($urandom_range(16'h0000, 16'h007F)), eos);
    end else if (pick < 45) begin
      send_unit(16'($urandom_range(16'h0080, 16'h07FF)), eos);
    end else if (pick < 60) begin
      if ($urandom_range(0, 1) == 0) begin
        send_unit(16'($urandom_range(16'h0800, 16'hD7FF)), eos);
      end else begin
        send_unit(16'($urandom_range(16'hE000, 16'hFFFF)), eos);
      end
    end else if (pick < 85) begin
      send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
      send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), eos);
    end else if (pick < 92) begin
      send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), eos);
    end else if (pick < 96) begin
      send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), eos);
    end else begin
      send_unit(16'($urandom_range(0, 16'hFFFF)), eos);
    end
  endtask

  initial begin
    sb = new;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'hD801, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hD802, 1'b0);
    send_unit(16'hD803, 1'b0);
    send_unit(16'hDC05, 1'b0);
    send_unit(16'hDBFF, 1'b1);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'hDA55, 1'b0);
    send_unit(16'hD9AA, 1'b1);
    send_unit(16'hD8F0, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'hD804, 1'b0);

    while (units_sent < 25 + RANDOM_UNITS) begin
      send_random_unit();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    $display("Transcoded %0d code units into %0d UTF-8 bytes.",
             sb.units_seen, sb.bytes_checked);
    $display("Covered %0d surrogate pairs and %0d flushed lone high surrogates.",
             sb.pairs_seen, sb.flushes_seen);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: utf16_to_utf8_transcoder_unit.f
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_queue.sv
rtl/u16u8_back.sv
rtl/utf16_to_utf8_transcoder_unit.sv
rtl/u16u8_checker.sv
bench/utf16_to_utf8_transcoder_unit_tb.sv
